FILE: hw/rtl/icaf_pkg.sv
// Shared types, widths, constants and the CORDIC angle table for the attitude filter.
package icaf_pkg;

    localparam int RAW_W    = 16;
    localparam int CORR_W   = 17;
    localparam int HD_W     = 25;
    localparam int ANG_W    = 25;
    localparam int RATE_W   = 22;
    localparam int ACC_W    = 23;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W   = 34;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 50;
    localparam int NUM_W    = 44;
    localparam int DEN_W    = 18;
    localparam int CX_W     = 32;
    localparam int CZ_W     = 34;
    localparam int SQ_W     = 50;
    localparam int SQ_TOP   = 48;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [CFG_W-1:0] DT_RESET = 16'd66;

    localparam int ANG_MAX  = 11796480;
    localparam int ANG_TURN = 23592960;

    localparam logic [DEN_W-1:0] DEN_INC  = 18'd82;
    localparam logic [DEN_W-1:0] DEN_RATE = 18'd41;
    localparam logic [DEN_W-1:0] DEN_Z    = 18'd163840;
    localparam logic [DEN_W-1:0] DEN_BL   = 18'd100;

    localparam int K_Z  = 573;
    localparam int K_BL = 98;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOFF_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOFF_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOFF_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_Z  = 3'd6;

    // axis / lane codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DG,
        OP_DIV_INC,
        OP_SAVE_INC,
        OP_DIV_RATE,
        OP_SAVE_RATE,
        OP_MUL_B,
        OP_MUL_C,
        OP_SUM_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORD_INIT,
        OP_CORD_STEP,
        OP_MUL_Z,
        OP_DIV_Z,
        OP_SAVE_TILT,
        OP_MUL_BL,
        OP_DIV_BL,
        OP_SAVE_BL,
        OP_WRAP,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic cord_done;
        logic wrap_done;
    } stat_t;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [CZ_W-1:0] atan_entry(input logic [5:0] i);
        logic signed [CZ_W-1:0] r;
        case (i)
            6'd0:    r = CZ_W'(843314857);
            6'd1:    r = CZ_W'(497837829);
            6'd2:    r = CZ_W'(263043837);
            6'd3:    r = CZ_W'(133525159);
            6'd4:    r = CZ_W'(67021687);
            6'd5:    r = CZ_W'(33543516);
            6'd6:    r = CZ_W'(16775851);
            6'd7:    r = CZ_W'(8388437);
            6'd8:    r = CZ_W'(4194283);
            6'd9:    r = CZ_W'(2097149);
            6'd10:   r = CZ_W'(1048576);
            default: r = (i <= 6'd30) ? (CZ_W'(1) <<< (6'd30 - i)) : '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/icaf_div.sv
// Constant divider by reciprocal multiplication, rounding to nearest with ties away from zero.
module icaf_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [icaf_pkg::NUM_W-1:0]  numer,
    input  logic        [icaf_pkg::DEN_W-1:0]  denom,
    output logic signed [icaf_pkg::NUM_W-1:0]  quot,
    output logic                               done
);
    import icaf_pkg::*;

    localparam int MAG_W = NUM_W + 1;
    localparam int M_W   = 36;          // magnitude after the power-of-two pre-shift
    localparam int H_W   = 18;          // half of the magnitude, one per multiply cycle
    localparam int R_W   = 38;
    localparam int SHR   = 40;          // reciprocals are ceil(2^40 / d)
    localparam int ACC_W = M_W + R_W;
    localparam int Q_W   = ACC_W - SHR;

    localparam int SH_INC = 1;          // 82  = 2 * 41
    localparam int SH_Z   = 15;         // 163840 = 2^15 * 5
    localparam int SH_BL  = 2;          // 100 = 4 * 25

    localparam logic [R_W-1:0] RCP_41 = 38'd26817356776;
    localparam logic [R_W-1:0] RCP_25 = 38'd43980465112;
    localparam logic [R_W-1:0] RCP_5  = 38'd219902325556;

    logic [M_W-1:0]   m_reg;
    logic [R_W-1:0]   rcp_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             neg_reg, hi_reg, busy_reg, done_reg;

    logic signed [MAG_W-1:0] ext;
    logic [MAG_W-1:0]        abs_n, mag, m_sh;
    logic [R_W-1:0]          rcp;
    logic [H_W-1:0]          mul_in;
    logic [H_W+R_W-1:0]      part;
    logic [Q_W-1:0]          q_mag;
    logic signed [NUM_W-1:0] q_ext;

    always_comb
    begin
        ext   = {numer[NUM_W-1], numer};
        abs_n = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
        mag   = abs_n + MAG_W'(denom >> 1);
        unique case (denom)
            DEN_INC:
            begin
                m_sh = mag >> SH_INC;
                rcp  = RCP_41;
            end
            DEN_RATE:
            begin
                m_sh = mag;
                rcp  = RCP_41;
            end
            DEN_Z:
            begin
                m_sh = mag >> SH_Z;
                rcp  = RCP_5;
            end
            default:    // blend divisor
            begin
                m_sh = mag >> SH_BL;
                rcp  = RCP_25;
            end
        endcase
        mul_in = hi_reg ? m_reg[M_W-1:H_W] : m_reg[H_W-1:0];
        part   = mul_in * rcp_reg;
        q_mag  = acc_reg[ACC_W-1:SHR];
        q_ext  = NUM_W'(q_mag);
    end

    // low half, then high half; done is raised in the cycle after the high half
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hi_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && hi_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                hi_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (hi_reg)
                begin
                    busy_reg <= 1'b0;
                    hi_reg   <= 1'b0;
                end
                else
                    hi_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg   <= M_W'(m_sh);
            rcp_reg <= rcp;
            neg_reg <= ext[MAG_W-1];
        end
        else if (busy_reg)
        begin
            if (!hi_reg)
                acc_reg <= ACC_W'(part);
            else
                acc_reg <= acc_reg + (ACC_W'(part) << H_W);
        end
    end

    assign quot = neg_reg ? -q_ext : q_ext;
    assign done = done_reg;

endmodule

FILE: hw/rtl/icaf_datapath.sv
// Datapath: config registers, shared multiplier, divider, square root, CORDIC and angle state.
module icaf_datapath #(
    parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  icaf_pkg::cmd_t                        cmd,
    output icaf_pkg::stat_t                       stat,
    input  logic                                  cfg_we,
    input  logic        [icaf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic        [icaf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_x_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_y_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_z_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_x_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_y_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_z_raw,
    input  logic signed [icaf_pkg::HD_W-1:0]      heading,
    output logic signed [icaf_pkg::ANG_W-1:0]     roll,
    output logic signed [icaf_pkg::ANG_W-1:0]     pitch,
    output logic signed [icaf_pkg::ANG_W-1:0]     yaw,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_x,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_y,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_z,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_x,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_y,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_z
);
    import icaf_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam logic [CNT_W-1:0] CI_LAST = CNT_W'(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] CI_ONE  = CNT_W'(1);
    localparam logic signed [WIDE_W-1:0] W_MAX  = WIDE_W'(ANG_MAX);
    localparam logic signed [WIDE_W-1:0] W_TURN = WIDE_W'(ANG_TURN);
    localparam logic signed [NUM_W-1:0]  N_MAX  = NUM_W'(ANG_MAX);

    // configuration
    logic        [CFG_W-1:0] dt_reg;
    logic signed [RAW_W-1:0] goff_reg [3];
    logic signed [RAW_W-1:0] aoff_reg [3];

    // sample
    logic signed [CORR_W-1:0] g_reg [3];
    logic signed [CORR_W-1:0] a_reg [3];
    logic signed [HD_W-1:0]   hd_reg;

    // working values
    logic signed [ANG_W-1:0]  ang_reg  [3];
    logic signed [WIDE_W-1:0] ang1_reg [3];
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [ANG_W-1:0]  tilt_reg [2];
    logic signed [WIDE_W-1:0] yaw2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic        [SQ_W-1:0]   sq_reg, n_reg, res_reg, bit_reg;
    logic signed [CX_W-1:0]   cx_reg, cy_reg;
    logic signed [CZ_W-1:0]   cz_reg;
    logic        [CNT_W-1:0]  ci_reg;
    logic                     czero_reg;

    // outputs
    logic signed [ANG_W-1:0]  roll_reg, pitch_reg, yaw_reg;
    logic signed [RATE_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [ACC_W-1:0]  ax_reg, ay_reg, az_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [NUM_W-1:0]   num, q;
    logic        [DEN_W-1:0]   den;
    logic                      div_start, div_done;
    logic signed [CORR_W-1:0]  tb;
    logic signed [CX_W-1:0]    ta, dx, dy;
    logic signed [ANG_W-1:0]   bl_add;
    logic signed [WIDE_W-1:0]  qa, y1;
    logic signed [NUM_W-1:0]   qsat;
    logic        [SQ_W-1:0]    sq_t;
    logic                      differ;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= DT_RESET;
            for (int i = 0; i < 3; i++)
            begin
                goff_reg[i] <= '0;
                aoff_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_DT:     dt_reg      <= cfg_wdata;
                REG_GOFF_X: goff_reg[0] <= $signed(cfg_wdata);
                REG_GOFF_Y: goff_reg[1] <= $signed(cfg_wdata);
                REG_GOFF_Z: goff_reg[2] <= $signed(cfg_wdata);
                REG_AOFF_X: aoff_reg[0] <= $signed(cfg_wdata);
                REG_AOFF_Y: aoff_reg[1] <= $signed(cfg_wdata);
                REG_AOFF_Z: aoff_reg[2] <= $signed(cfg_wdata);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        tb    = cmd.axis[0] ? a_reg[1] : a_reg[0];
        case (cmd.op)
            OP_MUL_DG:
            begin
                mul_a = MUL_W'({1'b0, dt_reg});
                mul_b = MUL_W'(g_reg[cmd.axis]);
            end
            OP_MUL_B:
            begin
                mul_a = MUL_W'(tb) <<< 8;
                mul_b = MUL_W'(tb) <<< 8;
            end
            OP_MUL_C:
            begin
                mul_a = MUL_W'(a_reg[2]) <<< 8;
                mul_b = MUL_W'(a_reg[2]) <<< 8;
            end
            OP_MUL_Z:
            begin
                mul_a = MUL_W'(cz_reg);
                mul_b = MUL_W'(K_Z);
            end
            OP_MUL_BL:
            begin
                mul_a = MUL_W'(ang1_reg[cmd.axis]);
                mul_b = MUL_W'(K_BL);
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        num       = '0;
        den       = DEN_BL;
        div_start = 1'b0;
        bl_add    = (cmd.axis == AX_Z) ? hd_reg : tilt_reg[cmd.axis[0]];
        case (cmd.op)
            OP_DIV_INC:
            begin
                num       = NUM_W'(prod_reg <<< 2) + NUM_W'(prod_reg);
                den       = DEN_INC;
                div_start = 1'b1;
            end
            OP_DIV_RATE:
            begin
                num       = (NUM_W'(g_reg[cmd.axis]) <<< 9) + (NUM_W'(g_reg[cmd.axis]) <<< 7);
                den       = DEN_RATE;
                div_start = 1'b1;
            end
            OP_DIV_Z:
            begin
                num       = NUM_W'(prod_reg);
                den       = DEN_Z;
                div_start = 1'b1;
            end
            OP_DIV_BL:
            begin
                num       = NUM_W'(prod_reg) + (NUM_W'(bl_add) <<< 1);
                den       = DEN_BL;
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    icaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num),
        .denom (den),
        .quot  (q),
        .done  (div_done)
    );

    always_comb
    begin
        ta     = cmd.axis[0] ? -CX_W'(a_reg[0]) : CX_W'(a_reg[1]);
        dx     = cx_reg >>> ci_reg;
        dy     = cy_reg >>> ci_reg;
        sq_t   = res_reg + bit_reg;
        qa     = WIDE_W'(q);
        y1     = ang1_reg[2];
        differ = (y1 < 0 && hd_reg > 0) || (y1 > 0 && hd_reg < 0);
        if (q > N_MAX)
            qsat = N_MAX;
        else if (q < -N_MAX)
            qsat = -N_MAX;
        else
            qsat = q;
    end

    // attitude state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                ang_reg[i] <= '0;
        end
        else if (cmd.op == OP_SAVE_BL && cmd.axis != AX_Z)
            ang_reg[cmd.axis] <= ANG_W'(qsat);
        else if (cmd.op == OP_OUT)
            ang_reg[2] <= ANG_W'(yaw2_reg);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                g_reg[0] <= CORR_W'(gyro_x_raw)  - CORR_W'(goff_reg[0]);
                g_reg[1] <= CORR_W'(gyro_y_raw)  - CORR_W'(goff_reg[1]);
                g_reg[2] <= CORR_W'(gyro_z_raw)  - CORR_W'(goff_reg[2]);
                a_reg[0] <= CORR_W'(accel_x_raw) - CORR_W'(aoff_reg[0]);
                a_reg[1] <= CORR_W'(accel_y_raw) - CORR_W'(aoff_reg[1]);
                a_reg[2] <= CORR_W'(accel_z_raw) - CORR_W'(aoff_reg[2]);
                hd_reg   <= heading;
            end
            OP_MUL_DG, OP_MUL_B, OP_MUL_Z, OP_MUL_BL:
                prod_reg <= PROD_W'(mul_p);
            OP_MUL_C:
            begin
                sq_reg   <= SQ_W'(prod_reg);
                prod_reg <= PROD_W'(mul_p);
            end
            OP_SUM_SQ:
                sq_reg <= sq_reg + SQ_W'(prod_reg);
            OP_SAVE_INC:
            begin
                if (cmd.axis == AX_Z)
                    ang1_reg[2] <= WIDE_W'(ang_reg[2]) - qa;
                else
                    ang1_reg[cmd.axis] <= WIDE_W'(ang_reg[cmd.axis]) + qa;
            end
            OP_SAVE_RATE:
                rate_reg[cmd.axis] <= RATE_W'(q);
            OP_SQRT_INIT:
            begin
                n_reg   <= sq_reg;
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << SQ_TOP;
            end
            OP_SQRT_STEP:
            begin
                if (bit_reg != '0)
                begin
                    if (n_reg >= sq_t)
                    begin
                        n_reg   <= n_reg - sq_t;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
            end
            OP_CORD_INIT:
            begin
                cx_reg    <= CX_W'(res_reg);
                cy_reg    <= ta <<< 8;
                cz_reg    <= '0;
                ci_reg    <= '0;
                czero_reg <= (ta == '0);
            end
            OP_CORD_STEP:
            begin
                if (!czero_reg && ci_reg != CI_LAST)
                begin
                    if (!cy_reg[CX_W-1])
                    begin
                        cx_reg <= cx_reg + dy;
                        cy_reg <= cy_reg - dx;
                        cz_reg <= cz_reg + atan_entry(6'(ci_reg));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - dy;
                        cy_reg <= cy_reg + dx;
                        cz_reg <= cz_reg - atan_entry(6'(ci_reg));
                    end
                    ci_reg <= ci_reg + CI_ONE;
                end
            end
            OP_SAVE_TILT:
                tilt_reg[cmd.axis[0]] <= ANG_W'(q);
            OP_SAVE_BL:
            begin
                if (cmd.axis == AX_Z)
                    yaw2_reg <= differ ? WIDE_W'(hd_reg) : qa;
            end
            OP_WRAP:
            begin
                if (yaw2_reg > W_MAX)
                    yaw2_reg <= yaw2_reg - W_TURN;
                else if (yaw2_reg < -W_MAX)
                    yaw2_reg <= yaw2_reg + W_TURN;
            end
            OP_OUT:
            begin
                roll_reg  <= ang_reg[0];
                pitch_reg <= ang_reg[1];
                yaw_reg   <= ANG_W'(yaw2_reg);
                rx_reg    <= rate_reg[0];
                ry_reg    <= rate_reg[1];
                rz_reg    <= rate_reg[2];
                ax_reg    <= ACC_W'(a_reg[0]) <<< 5;
                ay_reg    <= ACC_W'(a_reg[1]) <<< 5;
                az_reg    <= ACC_W'(a_reg[2]) <<< 5;
            end
            default: ;
        endcase
    end

    assign stat.div_done  = div_done;
    assign stat.sqrt_done = (bit_reg == '0);
    assign stat.cord_done = czero_reg || (ci_reg == CI_LAST);
    assign stat.wrap_done = (yaw2_reg <= W_MAX) && (yaw2_reg >= -W_MAX);

    assign roll   = roll_reg;
    assign pitch  = pitch_reg;
    assign yaw    = yaw_reg;
    assign rate_x = rx_reg;
    assign rate_y = ry_reg;
    assign rate_z = rz_reg;
    assign acc_x  = ax_reg;
    assign acc_y  = ay_reg;
    assign acc_z  = az_reg;

endmodule

FILE: hw/rtl/icaf_ctrl.sv
// Sequencer for the attitude filter: steps the datapath through one sample.
module icaf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  icaf_pkg::stat_t  stat,
    output icaf_pkg::cmd_t   cmd
);
    import icaf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INC_MUL, S_INC_DIV, S_INC_WAIT, S_INC_SAVE,
        S_RATE_DIV, S_RATE_WAIT, S_RATE_SAVE,
        S_T_MULB, S_T_MULC, S_T_SUM, S_T_SQI, S_T_SQS, S_T_CI, S_T_CS,
        S_T_MULZ, S_T_DIV, S_T_WAIT, S_T_SAVE,
        S_B_MUL, S_B_DIV, S_B_WAIT, S_B_SAVE,
        S_WRAP, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.axis       = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    k_next     = AX_X;
                    state_next = S_INC_MUL;
                end
            end
            S_INC_MUL:
            begin
                cmd.op     = OP_MUL_DG;
                state_next = S_INC_DIV;
            end
            S_INC_DIV:
            begin
                cmd.op     = OP_DIV_INC;
                state_next = S_INC_WAIT;
            end
            S_INC_WAIT:
                if (stat.div_done)
                    state_next = S_INC_SAVE;
            S_INC_SAVE:
            begin
                cmd.op = OP_SAVE_INC;
                if (k_reg == AX_Z)
                begin
                    k_next     = AX_X;
                    state_next = S_RATE_DIV;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_INC_MUL;
                end
            end
            S_RATE_DIV:
            begin
                cmd.op     = OP_DIV_RATE;
                state_next = S_RATE_WAIT;
            end
            S_RATE_WAIT:
                if (stat.div_done)
                    state_next = S_RATE_SAVE;
            S_RATE_SAVE:
            begin
                cmd.op = OP_SAVE_RATE;
                if (k_reg == AX_Z)
                begin
                    k_next     = AX_X;
                    state_next = S_T_MULB;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RATE_DIV;
                end
            end
            S_T_MULB:
            begin
                cmd.op     = OP_MUL_B;
                state_next = S_T_MULC;
            end
            S_T_MULC:
            begin
                cmd.op     = OP_MUL_C;
                state_next = S_T_SUM;
            end
            S_T_SUM:
            begin
                cmd.op     = OP_SUM_SQ;
                state_next = S_T_SQI;
            end
            S_T_SQI:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_T_SQS;
            end
            S_T_SQS:
            begin
                cmd.op = OP_SQRT_STEP;
                if (stat.sqrt_done)
                    state_next = S_T_CI;
            end
            S_T_CI:
            begin
                cmd.op     = OP_CORD_INIT;
                state_next = S_T_CS;
            end
            S_T_CS:
            begin
                cmd.op = OP_CORD_STEP;
                if (stat.cord_done)
                    state_next = S_T_MULZ;
            end
            S_T_MULZ:
            begin
                cmd.op     = OP_MUL_Z;
                state_next = S_T_DIV;
            end
            S_T_DIV:
            begin
                cmd.op     = OP_DIV_Z;
                state_next = S_T_WAIT;
            end
            S_T_WAIT:
                if (stat.div_done)
                    state_next = S_T_SAVE;
            S_T_SAVE:
            begin
                cmd.op = OP_SAVE_TILT;
                if (k_reg == AX_Y)
                begin
                    k_next     = AX_X;
                    state_next = S_B_MUL;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_T_MULB;
                end
            end
            S_B_MUL:
            begin
                cmd.op     = OP_MUL_BL;
                state_next = S_B_DIV;
            end
            S_B_DIV:
            begin
                cmd.op     = OP_DIV_BL;
                state_next = S_B_WAIT;
            end
            S_B_WAIT:
                if (stat.div_done)
                    state_next = S_B_SAVE;
            S_B_SAVE:
            begin
                cmd.op = OP_SAVE_BL;
                if (k_reg == AX_Z)
                    state_next = S_WRAP;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_B_MUL;
                end
            end
            S_WRAP:
            begin
                cmd.op = OP_WRAP;
                if (stat.wrap_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= AX_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/imu_complementary_attitude_filter_top.sv
// Top level of the complementary roll/pitch/yaw attitude filter.
//
//  channel   direction  handshake              payload
//  ------------------------------------------------------------------------------
//  sample    in         in_valid / in_ready    gyro_*_raw, accel_*_raw, heading
//  result    out        out_valid / out_ready  roll, pitch, yaw, rate_*, acc_*
//  config    in         cfg_we (no wait)       cfg_idx, cfg_wdata
//
//  Sample beats are taken only in idle, once the previous pass is through. A pass
//  runs the 25-step square root and the CORDIC, each twice, and eleven roundings
//  on the shared reciprocal divider; the CORDIC steps are skipped for a tilt whose
//  numerator is zero, and each 360 degree yaw wrap adds a wrap step. Reset clears
//  the angle state and loads the config defaults (dt = 66).
//  A finished result waits in the output register; the next sample beat is taken
//  meanwhile, and only the final hand-over stalls while out_ready stays low.
module imu_complementary_attitude_filter_top #(
    parameter int CORDIC_STEPS = icaf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [icaf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic        [icaf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_x_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_y_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     gyro_z_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_x_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_y_raw,
    input  logic signed [icaf_pkg::RAW_W-1:0]     accel_z_raw,
    input  logic signed [icaf_pkg::HD_W-1:0]      heading,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [icaf_pkg::ANG_W-1:0]     roll,
    output logic signed [icaf_pkg::ANG_W-1:0]     pitch,
    output logic signed [icaf_pkg::ANG_W-1:0]     yaw,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_x,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_y,
    output logic signed [icaf_pkg::RATE_W-1:0]    rate_z,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_x,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_y,
    output logic signed [icaf_pkg::ACC_W-1:0]     acc_z
);
    import icaf_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns the handshakes and walks the per-sample micro-steps
    icaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: offsets, integration, tilt (isqrt + CORDIC), blends, yaw wrap
    icaf_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .gyro_x_raw  (gyro_x_raw),
        .gyro_y_raw  (gyro_y_raw),
        .gyro_z_raw  (gyro_z_raw),
        .accel_x_raw (accel_x_raw),
        .accel_y_raw (accel_y_raw),
        .accel_z_raw (accel_z_raw),
        .heading     (heading),
        .roll        (roll),
        .pitch       (pitch),
        .yaw         (yaw),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .acc_z       (acc_z)
    );

    // a sample beat starts a multi-cycle pass: no second beat next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample accepted while a pass was running");

    // a result only appears at the end of a pass
    a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised without a completed pass");

    // roll and pitch are saturated, yaw is wrapped
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll <= ANG_MAX && roll >= -ANG_MAX &&
                       pitch <= ANG_MAX && pitch >= -ANG_MAX &&
                       yaw <= ANG_MAX && yaw >= -ANG_MAX))
        else $error("output angle beyond +-180 degrees");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the complementary roll/pitch/yaw attitude filter.
`timescale 1ns / 100ps

module tb;
    import icaf_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  RESET_CYC   = 8;
    localparam int  SETTLE_CYC  = 800;      // several times one sample's latency
    localparam longint CYC_LIMIT = 3000000;
    localparam int  RAND_ITEMS  = 160;      // per phase, four phases

    typedef struct {
        logic signed [RAW_W-1:0] gx, gy, gz, ax, ay, az;
        logic signed [HD_W-1:0]  hd;
    } sample_t;

    typedef struct {
        logic signed [ANG_W-1:0]  roll, pitch, yaw;
        logic signed [RATE_W-1:0] rx, ry, rz;
        logic signed [ACC_W-1:0]  acx, acy, acz;
    } attitude_t;

    // Attitude predictor and queue of pending attitudes.
    class attitude_board;
        longint    period;
        longint    g_off [3];
        longint    a_off [3];
        longint    roll_q16, pitch_q16, yaw_q16;
        attitude_t pending[$];
        int        errors;
        longint    atan_q30 [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

        function void clear();
            period = 66;
            foreach (g_off[i]) g_off[i] = 0;
            foreach (a_off[i]) a_off[i] = 0;
            roll_q16 = 0; pitch_q16 = 0; yaw_q16 = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DT:     period   = longint'(val);
                REG_GOFF_X: g_off[0] = longint'($signed(val));
                REG_GOFF_Y: g_off[1] = longint'($signed(val));
                REG_GOFF_Z: g_off[2] = longint'($signed(val));
                REG_AOFF_X: a_off[0] = longint'($signed(val));
                REG_AOFF_Y: a_off[1] = longint'($signed(val));
                REG_AOFF_Z: a_off[2] = longint'($signed(val));
                default: ;
            endcase
        endfunction

        // nearest, ties away from zero
        function longint round_div(longint n, longint d);
            if (n >= 0) return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        function longint clamp_angle(longint v);
            if (v > ANG_MAX) return ANG_MAX;
            if (v < -ANG_MAX) return -ANG_MAX;
            return v;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned res, bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > n) bits >>= 2;
            while (bits != 0) begin
                if (n >= res + bits) begin
                    n -= res + bits;
                    res = (res >> 1) + bits;
                end else
                    res >>= 1;
                bits >>= 2;
            end
            return res;
        endfunction

        function longint atan_step(int i);
            if (i < 11) return atan_q30[i];
            if (i <= 30) return longint'(1) << (30 - i);
            return 0;
        endfunction

        // vectoring atan2(y, x), x >= 0, in Q16 degrees
        function longint atan2_deg(longint y, longint x);
            longint z, nx, ny;
            z = 0;
            if (y == 0) return 0;
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
                if (y >= 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += atan_step(i);
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= atan_step(i);
                end
                x = nx;
                y = ny;
            end
            return round_div(z * 573, 163840);
        endfunction

        function longint tilt_deg(longint a, longint b, longint c);
            longint bs, cs;
            bs = b * 256;
            cs = c * 256;
            return atan2_deg(a * 256, longint'(int_root(longint'(bs * bs + cs * cs))));
        endfunction

        function void note_sample(sample_t s);
            longint gx, gy, gz, ax, ay, az, hd, r1, p1, y1, y2, phi, theta;
            attitude_t e;
            gx = longint'(s.gx) - g_off[0];
            gy = longint'(s.gy) - g_off[1];
            gz = longint'(s.gz) - g_off[2];
            ax = longint'(s.ax) - a_off[0];
            ay = longint'(s.ay) - a_off[1];
            az = longint'(s.az) - a_off[2];
            hd = longint'(s.hd);
            r1 = roll_q16  + round_div(period * gx * 5, 82);
            p1 = pitch_q16 + round_div(period * gy * 5, 82);
            y1 = yaw_q16   - round_div(period * gz * 5, 82);
            phi   = tilt_deg(ay, ax, az);
            theta = tilt_deg(-ax, ay, az);
            roll_q16  = clamp_angle(round_div(98 * r1 + 2 * phi, 100));
            pitch_q16 = clamp_angle(round_div(98 * p1 + 2 * theta, 100));
            if ((y1 < 0 && hd > 0) || (y1 > 0 && hd < 0))
                y2 = hd;
            else
                y2 = round_div(98 * y1 + 2 * hd, 100);
            while (y2 > ANG_MAX) y2 -= ANG_TURN;
            while (y2 < -ANG_MAX) y2 += ANG_TURN;
            yaw_q16 = y2;
            e.roll  = ANG_W'(roll_q16);
            e.pitch = ANG_W'(pitch_q16);
            e.yaw   = ANG_W'(yaw_q16);
            e.rx    = RATE_W'(round_div(gx * 640, 41));
            e.ry    = RATE_W'(round_div(gy * 640, 41));
            e.rz    = RATE_W'(round_div(gz * 640, 41));
            e.acx   = ACC_W'(ax * 32);
            e.acy   = ACC_W'(ay * 32);
            e.acz   = ACC_W'(az * 32);
            pending.push_back(e);
        endfunction

        function void same(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(attitude_t a);
            attitude_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            same("roll",   e.roll,  a.roll);
            same("pitch",  e.pitch, a.pitch);
            same("yaw",    e.yaw,   a.yaw);
            same("rate_x", e.rx,    a.rx);
            same("rate_y", e.ry,    a.ry);
            same("rate_z", e.rz,    a.rz);
            same("acc_x",  e.acx,   a.acx);
            same("acc_y",  e.acy,   a.acy);
            same("acc_z",  e.acz,   a.acz);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_W-1:0]        cfg_wdata;
    logic                    in_valid, in_ready;
    logic signed [RAW_W-1:0] gyro_x_raw, gyro_y_raw, gyro_z_raw;
    logic signed [RAW_W-1:0] accel_x_raw, accel_y_raw, accel_z_raw;
    logic signed [HD_W-1:0]  heading;
    logic                    out_valid, out_ready;
    logic signed [ANG_W-1:0] roll, pitch, yaw;
    logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
    logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

    attitude_board board;
    int            send_idle_pct;   // chance per cycle the sender holds back
    int            recv_stall_pct;  // chance per cycle the receiver stalls
    longint        cycles;

    imu_complementary_attitude_filter_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .gyro_x_raw  (gyro_x_raw),
        .gyro_y_raw  (gyro_y_raw),
        .gyro_z_raw  (gyro_z_raw),
        .accel_x_raw (accel_x_raw),
        .accel_y_raw (accel_y_raw),
        .accel_z_raw (accel_z_raw),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .roll        (roll),
        .pitch       (pitch),
        .yaw         (yaw),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .acc_z       (acc_z)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random back-pressure, every accepted beat goes to the board.
    // Values read here are the ones from before this edge, so no race with the DUT.
    always @(posedge clk)
    begin
        attitude_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.roll = roll;    got.pitch = pitch;  got.yaw = yaw;
            got.rx = rate_x;    got.ry = rate_y;    got.rz = rate_z;
            got.acx = acc_x;    got.acy = acc_y;    got.acz = acc_z;
            board.check_result(got);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One register write; DUT is idle whenever this is called.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // Called on a clock edge; returns on the edge the beat was taken.
    task automatic send_sample(sample_t s);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        gyro_x_raw  <= s.gx;  gyro_y_raw  <= s.gy;  gyro_z_raw  <= s.gz;
        accel_x_raw <= s.ax;  accel_y_raw <= s.ay;  accel_z_raw <= s.az;
        heading     <= s.hd;
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
        board.note_sample(s);
    endtask

    // Wait for every expected beat, then a full latency so the core is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic sample_t mk(int gx, int gy, int gz, int ax, int ay, int az, int hd);
        sample_t s;
        s.gx = RAW_W'(gx); s.gy = RAW_W'(gy); s.gz = RAW_W'(gz);
        s.ax = RAW_W'(ax); s.ay = RAW_W'(ay); s.az = RAW_W'(az);
        s.hd = HD_W'(hd);
        return s;
    endfunction

    // Mostly plausible motion with a sensor near one g; the rest raw noise.
    function automatic sample_t rand_sample();
        sample_t s;
        if ($urandom_range(99) < 70)
            s = mk(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                   int'($urandom_range(4000)) - 2000, int'($urandom_range(4096)) - 2048,
                   int'($urandom_range(4096)) - 2048, 2048 + int'($urandom_range(512)) - 256,
                   int'($urandom_range(2 * ANG_MAX)) - ANG_MAX);
        else
            s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return s;
    endfunction

    task automatic load_config(logic [CFG_W-1:0] period, logic [CFG_W-1:0] goff,
                               logic [CFG_W-1:0] aoff, bit rand_offs);
        write_reg(REG_DT, period);
        write_reg(REG_GOFF_X, rand_offs ? CFG_W'($urandom) : goff);
        write_reg(REG_GOFF_Y, rand_offs ? CFG_W'($urandom) : goff);
        write_reg(REG_GOFF_Z, rand_offs ? CFG_W'($urandom) : goff);
        write_reg(REG_AOFF_X, rand_offs ? CFG_W'($urandom) : aoff);
        write_reg(REG_AOFF_Y, rand_offs ? CFG_W'($urandom) : aoff);
        write_reg(REG_AOFF_Z, rand_offs ? CFG_W'($urandom) : aoff);
    endtask

    initial
    begin
        sample_t directed[$];
        board = new();
        board.clear();
        cycles         = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        gyro_x_raw     = '0; gyro_y_raw  = '0; gyro_z_raw  = '0;
        accel_x_raw    = '0; accel_y_raw = '0; accel_z_raw = '0;
        heading        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at reset config: zero vector, field extremes,
        // heading sign flips, out-of-range headings, near-180 yaw.
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, 0, 0, 2048, 0));
        directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, ANG_MAX));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -ANG_MAX));
        directed.push_back(mk(32767, -32768, 100, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 1000, 0, 5, 0, 655360));
        directed.push_back(mk(0, 0, -1000, 7, 0, 0, -655360));
        directed.push_back(mk(0, 0, 0, 2048, 0, 0, 16777215));
        directed.push_back(mk(0, 0, 0, 0, 2048, 0, -16777216));
        directed.push_back(mk(0, 0, 0, -2048, -2048, 0, ANG_MAX));
        directed.push_back(mk(0, 0, 0, 0, 0, -2048, ANG_MAX + 1));
        directed.push_back(mk(-1, 1, -1, 1, -1, 1, -1));
        directed.push_back(mk(164, -164, 0, 1, 1, 1, 1));
        directed.push_back(mk(0, 0, -32768, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 32767, 0, 0, 0, 0));
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        // dt zero: integration vanishes, blend still runs
        write_reg(REG_DT, '0);
        send_sample(mk(32767, 32767, 32767, 100, 200, 2048, 1000));
        send_sample(mk(0, 0, 0, 0, 0, 0, -1000));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_config(16'hFFFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
                1: load_config(16'd1, 16'sh8000, 16'sh8000, 1'b0);
                2: load_config(16'd66, '0, '0, 1'b1);
                default: load_config(CFG_W'($urandom_range(65535, 1)), '0, '0, 1'b1);
            endcase
            send_idle_pct  = (phase == 1 || phase == 0) ? (phase == 1 ? 72 : 0) :
                             (phase == 2 ? 0 : 30);
            recv_stall_pct = (phase == 2) ? 72 : (phase == 3 ? 30 : 0);
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                // a mid-phase pause until the pipe is empty
                if (n == RAND_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    while (board.pending.size() != 0) @(posedge clk);
                end
                send_sample(rand_sample());
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
